// File: src/sdpd_pkg.sv
// Shared types, widths and codes for the straight-drive PD controller.
package sdpd_pkg;

  localparam int POS_WIDTH = 21;
  localparam int DIST_W    = 20;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 15;
  localparam int TMO_W     = 16;
  localparam int VEL_W     = 17;
  localparam int TIME_W    = 32;
  localparam int DRIVE_W   = 16;

  localparam int AX_W      = (POS_WIDTH > DIST_W) ? POS_WIDTH : DIST_W;
  localparam int MUL_W     = DIST_W;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int RAD_W     = 2 * DIST_W + 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int SQ_CNT_W  = $clog2(ROOT_W);
  localparam int P_W       = GAIN_W + DIST_W;
  localparam int DIFF_W    = P_W + 1;
  localparam int SHIFT     = 10;
  localparam int RAW_W     = DIFF_W - SHIFT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIST_W;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(256);
  localparam logic [LIM_W-1:0]  EFFORT_RST = LIM_W'(25600);

  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P,
    CFG_GAIN_D,
    CFG_EFFORT,
    CFG_TIMEOUT,
    CFG_REVERSE,
    CFG_TARGET
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIFF,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_T,
    S_CMP,
    S_ROOT_D,
    S_VEL_X,
    S_VEL_Y,
    S_VEL_SUM,
    S_VEL_GO,
    S_ROOT_V,
    S_MUL_P,
    S_MUL_D,
    S_SUB,
    S_CLAMP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

// File: src/straight_drive_pd_controller_top.sv
// Straight-drive PD controller: sequencer, datapath and channel registers.
//
// Input channel (in_valid/in_ready) takes one item: operation 0 arms a new
// move and gives no result; operation 1 is a control tick and gives exactly
// one result (drive_command, finished) on the output channel.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; write them only while the block is idle.
// An arm item is handled in the idle state. A tick that ends on a far axis
// offset or on the timeout stops after the difference step; one that ends
// on the squared distance stops after the compare. A running tick takes the
// iterative square root of the distance, then of the speed if error is left;
// multiplies share one registered 20x20 multiplier, one product per cycle.
// The block handles one item at a time and drops in_ready while working.
// The result sits in an output register: a new item is taken while it waits,
// and the next result is held back until the receiver takes the old one.
// Reset loads the register defaults, clears the latched start point and
// time, and makes the first tick latch its own position and time.
module straight_drive_pd_controller_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   operation,
  input  logic signed [sdpd_pkg::POS_WIDTH-1:0]  pos_x,
  input  logic signed [sdpd_pkg::POS_WIDTH-1:0]  pos_y,
  input  logic signed [sdpd_pkg::VEL_W-1:0]      vel_x,
  input  logic signed [sdpd_pkg::VEL_W-1:0]      vel_y,
  input  logic [sdpd_pkg::TIME_W-1:0]            now_ms,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [sdpd_pkg::DRIVE_W-1:0]    drive_command,
  output logic                                   finished,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sdpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sdpd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // configuration
  logic [sdpd_pkg::GAIN_W-1:0] gain_p;
  logic [sdpd_pkg::GAIN_W-1:0] gain_d;
  logic [sdpd_pkg::LIM_W-1:0]  effort_limit;
  logic [sdpd_pkg::TMO_W-1:0]  timeout_limit_ms;
  logic                        reverse;
  logic [sdpd_pkg::DIST_W-1:0] target_distance;

  // move state
  logic signed [sdpd_pkg::POS_WIDTH-1:0] start_x;
  logic signed [sdpd_pkg::POS_WIDTH-1:0] start_y;
  logic [sdpd_pkg::TIME_W-1:0]           start_time;
  logic                                  pending;

  // item and working registers
  logic signed [sdpd_pkg::POS_WIDTH-1:0] pos_x_r;
  logic signed [sdpd_pkg::POS_WIDTH-1:0] pos_y_r;
  logic signed [sdpd_pkg::VEL_W-1:0]     vel_x_r;
  logic signed [sdpd_pkg::VEL_W-1:0]     vel_y_r;
  logic [sdpd_pkg::TIME_W-1:0]           now_r;
  logic [sdpd_pkg::DIST_W-1:0]           ax_r;
  logic [sdpd_pkg::DIST_W-1:0]           ay_r;
  logic [sdpd_pkg::RAD_W-1:0]            acc;
  logic [sdpd_pkg::DIST_W-1:0]           err_r;
  logic [sdpd_pkg::VEL_W-1:0]            speed_r;
  logic signed [sdpd_pkg::RAW_W-1:0]     raw_r;
  logic signed [sdpd_pkg::DRIVE_W-1:0]   res_drive;
  logic                                  res_fin;

  sdpd_pkg::state_t state;
  sdpd_pkg::state_t state_next;

  logic in_acc;
  logic out_load;

  // shared units
  logic [sdpd_pkg::MUL_W-1:0]  mul_a;
  logic [sdpd_pkg::MUL_W-1:0]  mul_b;
  logic [sdpd_pkg::PROD_W-1:0] prod;
  logic                        sq_start;
  logic [sdpd_pkg::ROOT_W-1:0] sq_root;
  sdpd_pkg::sq_stat_t          sq_stat;

  // combinational datapath
  logic signed [sdpd_pkg::POS_WIDTH:0]   diff_x;
  logic signed [sdpd_pkg::POS_WIDTH:0]   diff_y;
  logic [sdpd_pkg::POS_WIDTH-1:0]        mag_x;
  logic [sdpd_pkg::POS_WIDTH-1:0]        mag_y;
  logic [sdpd_pkg::AX_W-1:0]             ax_c;
  logic [sdpd_pkg::AX_W-1:0]             ay_c;
  logic [sdpd_pkg::TIME_W-1:0]           elapsed;
  logic                                  quick_done;
  logic [sdpd_pkg::VEL_W-1:0]            vmag_x;
  logic [sdpd_pkg::VEL_W-1:0]            vmag_y;
  logic [sdpd_pkg::DIST_W-1:0]           err_c;
  logic [sdpd_pkg::DIFF_W-1:0]           diff_pd;
  logic signed [sdpd_pkg::RAW_W-1:0]     lim_s;
  logic signed [sdpd_pkg::RAW_W-1:0]     clamped;
  logic signed [sdpd_pkg::RAW_W-1:0]     drive_c;

  sdpd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sdpd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  assign in_ready  = (state == sdpd_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == sdpd_pkg::S_OUT) && (!out_valid || out_ready);

  always_comb begin
    diff_x   = (sdpd_pkg::POS_WIDTH + 1)'(pos_x_r) - (sdpd_pkg::POS_WIDTH + 1)'(start_x);
    diff_y   = (sdpd_pkg::POS_WIDTH + 1)'(pos_y_r) - (sdpd_pkg::POS_WIDTH + 1)'(start_y);
    mag_x    = diff_x[sdpd_pkg::POS_WIDTH] ? sdpd_pkg::POS_WIDTH'(-diff_x)
                                           : sdpd_pkg::POS_WIDTH'(diff_x);
    mag_y    = diff_y[sdpd_pkg::POS_WIDTH] ? sdpd_pkg::POS_WIDTH'(-diff_y)
                                           : sdpd_pkg::POS_WIDTH'(diff_y);
    ax_c     = sdpd_pkg::AX_W'(mag_x);
    ay_c     = sdpd_pkg::AX_W'(mag_y);
    elapsed  = now_r - start_time;
    quick_done = (ax_c > sdpd_pkg::AX_W'(target_distance))
              || (ay_c > sdpd_pkg::AX_W'(target_distance))
              || (elapsed > sdpd_pkg::TIME_W'(timeout_limit_ms));
    vmag_x   = vel_x_r[sdpd_pkg::VEL_W-1] ? sdpd_pkg::VEL_W'(-vel_x_r)
                                          : sdpd_pkg::VEL_W'(vel_x_r);
    vmag_y   = vel_y_r[sdpd_pkg::VEL_W-1] ? sdpd_pkg::VEL_W'(-vel_y_r)
                                          : sdpd_pkg::VEL_W'(vel_y_r);
    err_c    = target_distance - sq_root[sdpd_pkg::DIST_W-1:0];
    // p - d wraps into a two's complement word; the high bits are floor(/1024)
    diff_pd  = sdpd_pkg::DIFF_W'(acc) - sdpd_pkg::DIFF_W'(prod);
    lim_s    = $signed(sdpd_pkg::RAW_W'(effort_limit));
    if (raw_r > lim_s) begin
      clamped = lim_s;
    end else if (raw_r < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = raw_r;
    end
    drive_c  = reverse ? -clamped : clamped;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdpd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      sdpd_pkg::S_IDLE: begin
        if (in_acc && operation == sdpd_pkg::OP_TICK) begin
          state_next = sdpd_pkg::S_DIFF;
        end
      end
      sdpd_pkg::S_DIFF: begin
        state_next = quick_done ? sdpd_pkg::S_OUT : sdpd_pkg::S_SQ_X;
      end
      sdpd_pkg::S_SQ_X: begin
        mul_a      = ax_r;
        mul_b      = ax_r;
        state_next = sdpd_pkg::S_SQ_Y;
      end
      sdpd_pkg::S_SQ_Y: begin
        mul_a      = ay_r;
        mul_b      = ay_r;
        state_next = sdpd_pkg::S_SQ_T;
      end
      sdpd_pkg::S_SQ_T: begin
        mul_a      = target_distance;
        mul_b      = target_distance;
        state_next = sdpd_pkg::S_CMP;
      end
      sdpd_pkg::S_CMP: begin
        if (acc > sdpd_pkg::RAD_W'(prod)) begin
          state_next = sdpd_pkg::S_OUT;
        end else begin
          sq_start   = 1'b1;
          state_next = sdpd_pkg::S_ROOT_D;
        end
      end
      sdpd_pkg::S_ROOT_D: begin
        if (sq_stat.done) begin
          state_next = (err_c == '0) ? sdpd_pkg::S_CLAMP : sdpd_pkg::S_VEL_X;
        end
      end
      sdpd_pkg::S_VEL_X: begin
        mul_a      = sdpd_pkg::MUL_W'(vmag_x);
        mul_b      = sdpd_pkg::MUL_W'(vmag_x);
        state_next = sdpd_pkg::S_VEL_Y;
      end
      sdpd_pkg::S_VEL_Y: begin
        mul_a      = sdpd_pkg::MUL_W'(vmag_y);
        mul_b      = sdpd_pkg::MUL_W'(vmag_y);
        state_next = sdpd_pkg::S_VEL_SUM;
      end
      sdpd_pkg::S_VEL_SUM: begin
        state_next = sdpd_pkg::S_VEL_GO;
      end
      sdpd_pkg::S_VEL_GO: begin
        sq_start   = 1'b1;
        state_next = sdpd_pkg::S_ROOT_V;
      end
      sdpd_pkg::S_ROOT_V: begin
        if (sq_stat.done) begin
          state_next = sdpd_pkg::S_MUL_P;
        end
      end
      sdpd_pkg::S_MUL_P: begin
        mul_a      = sdpd_pkg::MUL_W'(gain_p);
        mul_b      = err_r;
        state_next = sdpd_pkg::S_MUL_D;
      end
      sdpd_pkg::S_MUL_D: begin
        mul_a      = sdpd_pkg::MUL_W'(gain_d);
        mul_b      = sdpd_pkg::MUL_W'(speed_r);
        state_next = sdpd_pkg::S_SUB;
      end
      sdpd_pkg::S_SUB: begin
        state_next = sdpd_pkg::S_CLAMP;
      end
      sdpd_pkg::S_CLAMP: begin
        state_next = sdpd_pkg::S_OUT;
      end
      sdpd_pkg::S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = sdpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sdpd_pkg::S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= sdpd_pkg::GAIN_P_RST;
      gain_d           <= '0;
      effort_limit     <= sdpd_pkg::EFFORT_RST;
      timeout_limit_ms <= '0;
      reverse          <= 1'b0;
      target_distance  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdpd_pkg::CFG_GAIN_P:  gain_p           <= cfg_data[sdpd_pkg::GAIN_W-1:0];
        sdpd_pkg::CFG_GAIN_D:  gain_d           <= cfg_data[sdpd_pkg::GAIN_W-1:0];
        sdpd_pkg::CFG_EFFORT:  effort_limit     <= cfg_data[sdpd_pkg::LIM_W-1:0];
        sdpd_pkg::CFG_TIMEOUT: timeout_limit_ms <= cfg_data[sdpd_pkg::TMO_W-1:0];
        sdpd_pkg::CFG_REVERSE: reverse          <= cfg_data[0];
        sdpd_pkg::CFG_TARGET:  target_distance  <= cfg_data[sdpd_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // move state: arm sets pending, the next tick latches the start point
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      start_time <= '0;
      pending    <= 1'b1;
    end else if (in_acc) begin
      if (operation == sdpd_pkg::OP_ARM) begin
        pending <= 1'b1;
      end else if (pending) begin
        start_x    <= pos_x;
        start_y    <= pos_y;
        start_time <= now_ms;
        pending    <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      sdpd_pkg::S_IDLE: begin
        if (in_acc) begin
          pos_x_r <= pos_x;
          pos_y_r <= pos_y;
          vel_x_r <= vel_x;
          vel_y_r <= vel_y;
          now_r   <= now_ms;
        end
      end
      sdpd_pkg::S_DIFF: begin
        ax_r      <= ax_c[sdpd_pkg::DIST_W-1:0];
        ay_r      <= ay_c[sdpd_pkg::DIST_W-1:0];
        // preset the finished result; a running tick overwrites it
        res_drive <= '0;
        res_fin   <= 1'b1;
      end
      sdpd_pkg::S_SQ_Y: begin
        acc <= sdpd_pkg::RAD_W'(prod);
      end
      sdpd_pkg::S_SQ_T: begin
        acc <= acc + sdpd_pkg::RAD_W'(prod);
      end
      sdpd_pkg::S_ROOT_D: begin
        if (sq_stat.done) begin
          err_r <= err_c;
          raw_r <= '0;
        end
      end
      sdpd_pkg::S_VEL_Y: begin
        acc <= sdpd_pkg::RAD_W'(prod);
      end
      sdpd_pkg::S_VEL_SUM: begin
        acc <= acc + sdpd_pkg::RAD_W'(prod);
      end
      sdpd_pkg::S_ROOT_V: begin
        if (sq_stat.done) begin
          speed_r <= sq_root[sdpd_pkg::VEL_W-1:0];
        end
      end
      sdpd_pkg::S_MUL_D: begin
        acc <= sdpd_pkg::RAD_W'(prod);
      end
      sdpd_pkg::S_SUB: begin
        raw_r <= $signed(diff_pd[sdpd_pkg::DIFF_W-1:sdpd_pkg::SHIFT]);
      end
      sdpd_pkg::S_CLAMP: begin
        res_drive <= sdpd_pkg::DRIVE_W'(drive_c);
        res_fin   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_command <= res_drive;
      finished      <= res_fin;
    end
  end

  a_fin_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> drive_command == '0)
    else $error("finished result with nonzero drive");

  a_sq_idle: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  a_tick_latch: assert property (@(posedge clk) disable iff (rst)
    in_acc && operation == sdpd_pkg::OP_TICK |=> !pending)
    else $error("start point not latched on tick");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == sdpd_pkg::S_OUT))
    else $error("result loaded outside output state");

endmodule

// File: src/sdpd_mul.sv
// Shared unsigned multiplier with a registered product.
module sdpd_mul (
  input  logic                         clk,
  input  logic [sdpd_pkg::MUL_W-1:0]   a,
  input  logic [sdpd_pkg::MUL_W-1:0]   b,
  output logic [sdpd_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= sdpd_pkg::PROD_W'(a) * sdpd_pkg::PROD_W'(b);
  end

endmodule

// File: src/sdpd_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module sdpd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sdpd_pkg::RAD_W-1:0]    radicand,
  output logic [sdpd_pkg::ROOT_W-1:0]   root,
  output sdpd_pkg::sq_stat_t            stat
);

  logic [sdpd_pkg::RAD_W-1:0]    rad;
  logic [sdpd_pkg::SQ_REM_W-1:0] rem;
  logic [sdpd_pkg::ROOT_W-1:0]   q;
  logic [sdpd_pkg::SQ_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;

  logic [sdpd_pkg::SQ_REM_W-1:0] rem_sh;
  logic [sdpd_pkg::SQ_REM_W-1:0] trial;
  logic [sdpd_pkg::SQ_REM_W-1:0] rem_next;
  logic [sdpd_pkg::ROOT_W-1:0]   q_next;

  always_comb begin
    // bring down the next two radicand bits
    rem_sh = {rem[sdpd_pkg::SQ_REM_W-3:0], rad[sdpd_pkg::RAD_W-1 -: 2]};
    trial  = sdpd_pkg::SQ_REM_W'({q, 2'b01});
    if (rem_sh >= trial) begin
      rem_next = rem_sh - trial;
      q_next   = {q[sdpd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      q_next   = {q[sdpd_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sdpd_pkg::SQ_CNT_W'(sdpd_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      rad <= {rad[sdpd_pkg::RAD_W-3:0], 2'b00};
      rem <= rem_next;
      q   <= q_next;
    end
  end

  assign root      = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: tb/straight_drive_pd_controller_top_tb.sv
// Self-checking testbench for the straight-drive PD controller: directed table, then random moves.
module straight_drive_pd_controller_top_tb;
  import sdpd_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    logic                        op;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [VEL_W-1:0]     vel_x;
    logic signed [VEL_W-1:0]     vel_y;
    logic [TIME_W-1:0]           now;
  } move_item_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      fin;
  } drive_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    move_item_t            it;
    bit                    typed;
    drive_res_t            res;
    cfg_reg_t              idx;
    longint                val;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic                         operation;
  logic signed [POS_WIDTH-1:0]  pos_x;
  logic signed [POS_WIDTH-1:0]  pos_y;
  logic signed [VEL_W-1:0]      vel_x;
  logic signed [VEL_W-1:0]      vel_y;
  logic [TIME_W-1:0]            now_ms;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [DRIVE_W-1:0]    drive_command;
  logic                         finished;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  // Register mirror and latched start of the move
  logic [GAIN_W-1:0]  kp;
  logic [GAIN_W-1:0]  kd;
  logic [LIM_W-1:0]   effort_cap;
  logic [TMO_W-1:0]   tmo_cap;
  logic               go_back;
  logic [DIST_W-1:0]  target_dist;
  longint             mv_start_x;
  longint             mv_start_y;
  logic [TIME_W-1:0]  mv_start_ms;
  bit                 latch_pending;

  drive_res_t pending_drives[$];
  dir_row_t   dir_rows[$];
  int         fault_cnt = 0;
  int         items_sent = 0;
  bit         quiet = 1'b0;
  int         stall_left = 0;

  straight_drive_pd_controller_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_command (drive_command),
    .finished      (finished),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned one;
    rem = n;
    root = 0;
    one = 64'd1 << 62;
    while (one > rem) one >>= 2;
    while (one != 0) begin
      if (rem >= root + one) begin
        rem -= root + one;
        root = (root >> 1) + one;
      end else begin
        root >>= 1;
      end
      one >>= 2;
    end
    return root;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Work out the result of one item and advance the start-point state
  task automatic predict_drive(input move_item_t it, output bit has_res,
                               output drive_res_t res);
    longint px, py, dx, dy, ax, ay, vx, vy, t, d2, moved, err, spd, p, d, drv, lim;
    logic [TIME_W-1:0] elapsed;
    bit done;
    has_res = 1'b0;
    res.drive = '0;
    res.fin = 1'b0;
    if (it.op == OP_ARM) begin
      latch_pending = 1'b1;
    end else begin
      has_res = 1'b1;
      px = longint'(it.pos_x);
      py = longint'(it.pos_y);
      vx = longint'(it.vel_x);
      vy = longint'(it.vel_y);
      if (latch_pending) begin
        mv_start_x = px;
        mv_start_y = py;
        mv_start_ms = it.now;
        latch_pending = 1'b0;
      end
      dx = px - mv_start_x;
      dy = py - mv_start_y;
      ax = mag(dx);
      ay = mag(dy);
      t = longint'(target_dist);
      elapsed = it.now - mv_start_ms;
      d2 = 0;
      done = (ax > t) || (ay > t);
      if (!done) begin
        d2 = ax * ax + ay * ay;
        done = d2 > t * t;
      end
      if (elapsed > tmo_cap) done = 1'b1;
      if (done) begin
        res.fin = 1'b1;
      end else begin
        moved = longint'(int_sqrt(d2));
        err = t - moved;
        drv = 0;
        if (err > 0) begin
          spd = longint'(int_sqrt(vx * vx + vy * vy));
          p = longint'(kp) * err;
          d = longint'(kd) * spd;
          // round toward minus infinity on the negative side
          if (p >= d) drv = (p - d) >>> 10;
          else drv = -(((d - p) + 1023) >>> 10);
        end
        lim = longint'(effort_cap);
        if (drv > lim) drv = lim;
        if (drv < -lim) drv = -lim;
        if (go_back) drv = -drv;
        res.drive = DRIVE_W'(drv);
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic int in_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 99) < 35) ? pick_gap() : 0;
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] rand_pos();
    return POS_WIDTH'($urandom);
  endfunction

  function automatic logic signed [VEL_W-1:0] rand_vel();
    if ($urandom_range(0, 1)) return VEL_W'($urandom);
    return VEL_W'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  function automatic move_item_t mk_item(input logic op, input longint px, input longint py,
                                         input longint vx, input longint vy,
                                         input longint now);
    move_item_t it;
    it.op = op;
    it.pos_x = POS_WIDTH'(px);
    it.pos_y = POS_WIDTH'(py);
    it.vel_x = VEL_W'(vx);
    it.vel_y = VEL_W'(vy);
    it.now = TIME_W'(now);
    return it;
  endfunction

  function automatic move_item_t rand_item(input logic op);
    return mk_item(op, longint'(rand_pos()), longint'(rand_pos()), longint'(rand_vel()),
                   longint'(rand_vel()), longint'($urandom));
  endfunction

  function automatic dir_row_t item_row(input move_item_t it, input int typed,
                                        input longint drv, input int fin);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.it = it;
    row.typed = (typed != 0);
    row.res.drive = DRIVE_W'(drv);
    row.res.fin = (fin != 0);
    row.idx = CFG_GAIN_P;
    row.val = 0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_reg_t idx, input longint val);
    dir_row_t row;
    row = item_row(mk_item(OP_ARM, 0, 0, 0, 0, 0), 0, 0, 0);
    row.kind = ROW_CFG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  task automatic send_item(input move_item_t it, input bit typed, input drive_res_t typed_res);
    bit has_res;
    drive_res_t res;
    int gap;
    in_valid <= 1'b1;
    operation <= it.op;
    pos_x <= it.pos_x;
    pos_y <= it.pos_y;
    vel_x <= it.vel_x;
    vel_y <= it.vel_y;
    now_ms <= it.now;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_drive(it, has_res, res);
    if (has_res) pending_drives.push_back(typed ? typed_res : res);
    gap = in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_plain(input move_item_t it);
    drive_res_t none;
    none.drive = '0;
    none.fin = 1'b0;
    send_item(it, 1'b0, none);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GAIN_P:  kp = GAIN_W'(val);
      CFG_GAIN_D:  kd = GAIN_W'(val);
      CFG_EFFORT:  effort_cap = LIM_W'(val);
      CFG_TIMEOUT: tmo_cap = TMO_W'(val);
      CFG_REVERSE: go_back = 1'(val);
      CFG_TARGET:  target_dist = DIST_W'(val);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let the block finish any arm item
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic longint ext_or_rand(input longint lo, input longint hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  task automatic config_phase(input int ph);
    longint tgt;
    drain_and_settle();
    if (ph == 0) begin
      write_reg(CFG_GAIN_P, 65535);
      write_reg(CFG_GAIN_D, 65535);
      write_reg(CFG_EFFORT, 25600);
      write_reg(CFG_TIMEOUT, 65535);
      write_reg(CFG_REVERSE, 1);
      write_reg(CFG_TARGET, 1048575);
    end else if (ph == 1) begin
      write_reg(CFG_GAIN_P, 0);
      write_reg(CFG_GAIN_D, 0);
      write_reg(CFG_EFFORT, 0);
      write_reg(CFG_TIMEOUT, 0);
      write_reg(CFG_REVERSE, 0);
      write_reg(CFG_TARGET, 0);
    end else begin
      if ($urandom_range(0, 99) < 20) tgt = ext_or_rand(0, 1048575);
      else tgt = longint'($urandom_range(0, (1 << $urandom_range(4, 20)) - 1));
      write_reg(CFG_GAIN_P, ext_or_rand(0, 65535));
      write_reg(CFG_GAIN_D, ($urandom_range(0, 3) == 0) ? 0 : ext_or_rand(0, 4095));
      write_reg(CFG_EFFORT, ext_or_rand(0, 25600));
      write_reg(CFG_TIMEOUT, ext_or_rand(0, 65535));
      write_reg(CFG_REVERSE, longint'($urandom_range(0, 1)));
      write_reg(CFG_TARGET, tgt);
    end
  endtask

  // Arm, then ticks that travel away from the start along one heading
  task automatic run_move();
    longint bx, by, cx, cy, s, s_max, el, el_max, t;
    logic [TIME_W-1:0] bt;
    int n;
    t = longint'(target_dist);
    bx = longint'(rand_pos());
    by = longint'(rand_pos());
    bt = $urandom;
    cx = longint'($urandom_range(0, 2048)) - 1024;
    cy = longint'(int_sqrt(1048576 - cx * cx));
    if ($urandom_range(0, 1)) cy = -cy;
    s_max = t + t / 8 + 2;
    el_max = longint'(tmo_cap) + longint'(tmo_cap) / 8 + 2;
    n = $urandom_range(1, 8);
    send_plain(rand_item(OP_ARM));
    s = 0;
    el = 0;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        s = longint'($urandom_range(int'(s_max), int'(s)));
        el = longint'($urandom_range(int'(el_max), int'(el)));
      end
      send_plain(mk_item(OP_TICK, bx + s * cx / 1024, by + s * cy / 1024,
                         longint'(rand_vel()), longint'(rand_vel()), longint'(bt) + el));
    end
  endtask

  // Ticks without an arm around the current start, or plain noise
  task automatic run_stray();
    longint span, el_max;
    int n;
    span = 2 * longint'(target_dist) + 2;
    el_max = longint'(tmo_cap) + 2;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        send_plain(rand_item(($urandom_range(0, 9) < 7) ? OP_TICK : OP_ARM));
      end else begin
        send_plain(mk_item(OP_TICK,
                           mv_start_x + longint'($urandom_range(0, int'(2 * span))) - span,
                           mv_start_y + longint'($urandom_range(0, int'(2 * span))) - span,
                           longint'(rand_vel()), longint'(rand_vel()),
                           longint'(mv_start_ms) + longint'($urandom_range(0, int'(el_max)))));
      end
    end
  endtask

  // Result side: check each accepted result, stall at random
  always @(posedge clk) begin
    drive_res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_drives.size() == 0) begin
          $display("%0t: unexpected item: drive_command %0d finished %0b",
                   $time, drive_command, finished);
          fault_cnt++;
        end else begin
          want = pending_drives.pop_front();
          if (drive_command !== want.drive) begin
            $display("%0t: drive_command expected %0d actual %0d",
                     $time, want.drive, drive_command);
            fault_cnt++;
          end
          if (finished !== want.fin) begin
            $display("%0t: finished expected %0b actual %0b", $time, want.fin, finished);
            fault_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("** straight_drive_pd_controller_top: FAILED **");
    $finish;
  end

  initial begin
    int phase_start;
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_ARM;
    pos_x = '0;
    pos_y = '0;
    vel_x = '0;
    vel_y = '0;
    now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GAIN_P;
    cfg_data = '0;
    kp = GAIN_P_RST;
    kd = '0;
    effort_cap = EFFORT_RST;
    tmo_cap = '0;
    go_back = 1'b0;
    target_dist = '0;
    mv_start_x = 0;
    mv_start_y = 0;
    mv_start_ms = '0;
    latch_pending = 1'b1;

    // Reset registers: zero target, zero timeout
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, 0, 0, 0), 1, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 1, 0, 0, 0, 0), 1, 0, 1));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, 0, 0, 1), 1, 0, 1));
    dir_rows.push_back(item_row(mk_item(OP_TICK, -1048576, 1048575, 65535, -65536, 0),
                                1, 0, 1));
    dir_rows.push_back(item_row(mk_item(OP_ARM, 123, -456, 0, 0, 7), 0, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 1048575, -1048576, -65536, 65535,
                                        32'hFFFF_FFFF), 1, 0, 0));
    // elapsed time wraps around zero
    dir_rows.push_back(item_row(mk_item(OP_TICK, 1048575, -1048576, 0, 0, 0), 1, 0, 1));
    dir_rows.push_back(cfg_row(CFG_TARGET, 1048575));
    dir_rows.push_back(cfg_row(CFG_TIMEOUT, 65535));
    dir_rows.push_back(cfg_row(CFG_GAIN_P, 65535));
    dir_rows.push_back(item_row(mk_item(OP_ARM, 0, 0, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, 0, 0, 100), 1, 25600, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, 0, 0, 65635), 1, 25600, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, 0, 0, 65636), 1, 0, 1));
    // exactly on the target: not finished, no error left
    dir_rows.push_back(item_row(mk_item(OP_TICK, 1048575, 0, 0, 0, 100), 1, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 1048575, 1, 0, 0, 100), 1, 0, 1));
    dir_rows.push_back(item_row(mk_item(OP_TICK, -1048576, 0, 0, 0, 100), 1, 0, 1));
    dir_rows.push_back(cfg_row(CFG_GAIN_P, 0));
    dir_rows.push_back(cfg_row(CFG_GAIN_D, 65535));
    dir_rows.push_back(cfg_row(CFG_REVERSE, 1));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, -65536, -65536, 100), 0, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, -1000, 2000, 65535, 0, 200), 0, 0, 0));
    dir_rows.push_back(cfg_row(CFG_EFFORT, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 0, 0, 100, 100, 300), 0, 0, 0));
    dir_rows.push_back(cfg_row(CFG_EFFORT, 25600));
    dir_rows.push_back(cfg_row(CFG_GAIN_P, 256));
    dir_rows.push_back(cfg_row(CFG_GAIN_D, 256));
    dir_rows.push_back(cfg_row(CFG_REVERSE, 0));
    dir_rows.push_back(cfg_row(CFG_TARGET, 1000));
    dir_rows.push_back(cfg_row(CFG_TIMEOUT, 50));
    dir_rows.push_back(item_row(mk_item(OP_ARM, 0, 0, 0, 0, 0), 0, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 500, -300, 300, 400, 5), 0, 0, 0));
    // derivative term wins: negative drive
    dir_rows.push_back(item_row(mk_item(OP_TICK, 800, 0, 1000, 0, 20), 0, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 1500, -300, 0, 0, 30), 0, 0, 0));
    dir_rows.push_back(item_row(mk_item(OP_TICK, 500, -300, 0, 0, 56), 1, 0, 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_and_settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      config_phase(ph);
      quiet = (ph == 2) || (ph == 5);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 85) run_move();
        else run_stray();
      end
    end

    drain_and_settle();
    if (fault_cnt == 0) begin
      $display("** straight_drive_pd_controller_top: PASSED **");
    end else begin
      $display("** straight_drive_pd_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
